// ----- rtl/nsd_pkg.sv -----
package nsd_pkg;

  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned DIVISOR_W  = DATA_WIDTH + FRAC_BITS;
  // greedy shift steps of 2^(NORM_STEPS-1) .. 1 cover any k below DATA_WIDTH
  localparam int unsigned NORM_STEPS = $clog2(DATA_WIDTH);
  localparam int unsigned CNT_W      = $clog2(DATA_WIDTH);

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] dividend;
    logic        [DIVISOR_W-1:0]  divisor;
  } nsd_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quotient;
    logic                         status;
  } nsd_rsp_t;

endpackage

// ----- rtl/normalized_signed_divider_core.sv -----
// normalized signed divider
//
// a transaction is taken on a rising edge with start high and busy low;
// req_i carries a signed dividend and an unsigned divisor with FRAC_BITS
// fraction bits. the result appears on rsp_o, marked by done_o, which is high
// for exactly one cycle; the receiver cannot stall it and must take it in that cycle.
// busy stays high from the accepting edge until the cycle done_o is high.
//
// sequence: a dividend of magnitude below the divisor, or a zero dividend,
// answers in the cycle after start, and busy never rises. the general case
// checks the operands, makes NORM_STEPS greedy left shifts (16, 8, 4, 2, 1)
// to normalize both operands, checks the scaled divisor, runs DATA_WIDTH
// restoring steps through one shared subtractor and then applies the sign.
// the next transaction may start in the cycle done_o is high.
// reset returns the sequencer to idle and drops done_o; no data is cleared.
// status reports a scaled divisor with a zero integer part (and a zero
// divisor) with quotient forced to zero.
module normalized_signed_divider_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  nsd_pkg::nsd_req_t req_i,
  output logic             done_o,
  output nsd_pkg::nsd_rsp_t rsp_o
);
  import nsd_pkg::*;

  localparam int unsigned TRIAL_W = 2 * DATA_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_CHECK,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                state_q, state_d;
  logic                  neg_q, neg_d;
  logic [DATA_WIDTH-1:0] mag_q, mag_d;
  logic [DIVISOR_W-1:0]  dv_q, dv_d;
  logic [DATA_WIDTH-1:0] rem_q, rem_d;
  logic [DATA_WIDTH-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  done_q, done_d;
  nsd_rsp_t              rsp_q, rsp_d;

  logic                  in_neg;
  logic [DATA_WIDTH-1:0] in_mag;
  logic [DIVISOR_W-1:0]  in_mag_scaled;
  logic [CNT_W-1:0]      sh_amt;
  logic [TRIAL_W-1:0]    norm_trial;
  logic [TRIAL_W-1:0]    norm_limit;
  logic [DATA_WIDTH-1:0] den;
  logic [DATA_WIDTH:0]   rem_trial;
  logic [DATA_WIDTH:0]   rem_diff;

  assign in_neg        = req_i.dividend[DATA_WIDTH-1];
  assign in_mag        = in_neg ? (~req_i.dividend + 1'b1) : req_i.dividend;
  assign in_mag_scaled = DIVISOR_W'(in_mag) << FRAC_BITS;

  // shift amounts run 2^(NORM_STEPS-1) down to 1
  assign sh_amt     = CNT_W'(NORM_STEPS - 1) - cnt_q;
  assign norm_trial = TRIAL_W'(mag_q) << (TRIAL_W'(1) << sh_amt);
  assign norm_limit = neg_q ? (TRIAL_W'(1) << (DATA_WIDTH - 1))
                            : ((TRIAL_W'(1) << (DATA_WIDTH - 1)) - 1'b1);

  // integer part of the scaled divisor
  assign den       = dv_q[DIVISOR_W-1:FRAC_BITS];
  assign rem_trial = {rem_q, mag_q[DATA_WIDTH-1]};
  assign rem_diff  = rem_trial - {1'b0, den};

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    dv_d    = dv_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          neg_d = in_neg;
          mag_d = in_mag;
          dv_d  = req_i.divisor;
          cnt_d = '0;
          if (in_mag == '0 && req_i.divisor == '0) begin
            done_d         = 1'b1;
            rsp_d.quotient = '0;
            rsp_d.status   = STATUS_ERR;
          end else if (in_mag_scaled < req_i.divisor) begin
            done_d         = 1'b1;
            rsp_d.quotient = '0;
            rsp_d.status   = STATUS_OK;
          end else begin
            state_d = ST_NORM;
          end
        end
      end

      ST_NORM: begin
        // largest k keeps the dividend in range; greedy over falling powers of two
        if (norm_trial <= norm_limit) begin
          mag_d = norm_trial[DATA_WIDTH-1:0];
          dv_d  = dv_q << (DIVISOR_W'(1) << sh_amt);
        end
        if (cnt_q == CNT_W'(NORM_STEPS - 1)) begin
          state_d = ST_CHECK;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_CHECK: begin
        rem_d = '0;
        quo_d = '0;
        cnt_d = '0;
        if (den == '0) begin
          done_d         = 1'b1;
          rsp_d.quotient = '0;
          rsp_d.status   = STATUS_ERR;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_DIV;
        end
      end

      ST_DIV: begin
        if (!rem_diff[DATA_WIDTH]) begin
          rem_d = rem_diff[DATA_WIDTH-1:0];
          quo_d = {quo_q[DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem_d = rem_trial[DATA_WIDTH-1:0];
          quo_d = {quo_q[DATA_WIDTH-2:0], 1'b0};
        end
        mag_d = mag_q << 1;
        if (cnt_q == CNT_W'(DATA_WIDTH - 1)) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_FIN: begin
        done_d         = 1'b1;
        rsp_d.quotient = neg_q ? (~quo_q + 1'b1) : quo_q;
        rsp_d.status   = STATUS_OK;
        state_d        = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
    dv_q  <= dv_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- tb/tb_normalized_signed_divider_core.sv -----
`timescale 1ns / 100ps

module tb_normalized_signed_divider_core;
  import nsd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam logic signed [DATA_WIDTH-1:0] DIVIDEND_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] DIVIDEND_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DIVISOR_W-1:0] ONE_FIXED = 1 << FRAC_BITS;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     dut_start = 1'b0;
  nsd_req_t dut_req = '0;
  logic     busy;
  logic     done_o;
  nsd_rsp_t rsp_o;

  nsd_req_t pending_divisions[$];
  nsd_rsp_t expected_quotients[$];
  logic     took_division = 1'b0;
  int       gap_left = 0;
  int       burst_left = 1;
  int       error_count = 0;

  normalized_signed_divider_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (dut_start),
    .busy   (busy),
    .req_i  (dut_req),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // scale both operands up, drop the divisor fraction, divide magnitudes
  function automatic nsd_rsp_t predict_quotient(nsd_req_t req);
    logic [63:0] raw;
    logic [63:0] mag;
    logic [63:0] lim;
    logic [63:0] dv;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    logic        neg;
    int unsigned k;
    nsd_rsp_t    rsp;
    raw = 64'(unsigned'(req.dividend));
    neg = raw[DATA_WIDTH-1];
    mag = neg ? ((64'd1 << DATA_WIDTH) - raw) : raw;
    lim = neg ? (64'd1 << (DATA_WIDTH - 1)) : ((64'd1 << (DATA_WIDTH - 1)) - 1);
    dv = 64'(req.divisor);
    rsp.quotient = '0;
    rsp.status = STATUS_OK;
    if (mag == 0 && dv == 0) begin
      rsp.status = STATUS_ERR;
    end else if ((mag << FRAC_BITS) >= dv) begin
      k = 0;
      while (k < DATA_WIDTH && (mag << (k + 1)) <= lim) k++;
      num = mag << k;
      den = (dv << k) >> FRAC_BITS;
      if (den == 0) begin
        rsp.status = STATUS_ERR;
      end else begin
        q = num / den;
        if (neg) q = -q;
        rsp.quotient = q[DATA_WIDTH-1:0];
      end
    end
    return rsp;
  endfunction

  task automatic queue_division(logic signed [DATA_WIDTH-1:0] dividend,
                                logic [DIVISOR_W-1:0] divisor);
    nsd_req_t req;
    req.dividend = dividend;
    req.divisor = divisor;
    pending_divisions.push_back(req);
  endtask

  function automatic nsd_req_t random_division();
    nsd_req_t    req;
    logic [63:0] wide;
    logic [63:0] mag;
    logic [63:0] top;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2: req.dividend = $urandom;
      3, 4:    req.dividend = $urandom_range(0, 2000);
      5: begin
        case ($urandom_range(0, 4))
          0: req.dividend = DIVIDEND_MIN;
          1: req.dividend = DIVIDEND_MAX;
          2: req.dividend = '0;
          3: req.dividend = 1;
          default: req.dividend = '1;
        endcase
      end
      default: req.dividend = $urandom >> $urandom_range(0, DATA_WIDTH - 1);
    endcase
    if ($urandom_range(0, 1) && req.dividend != DIVIDEND_MIN) req.dividend = -req.dividend;
    mag = req.dividend[DATA_WIDTH-1] ? ((64'd1 << DATA_WIDTH) - 64'(unsigned'(req.dividend)))
                                     : 64'(unsigned'(req.dividend));
    top = mag << FRAC_BITS;
    case ($urandom_range(0, 9))
      0, 1: req.divisor = wide[DIVISOR_W-1:0] >> $urandom_range(0, DIVISOR_W - 1);
      2:    req.divisor = top[DIVISOR_W-1:0];
      3:    req.divisor = $urandom_range(0, (1 << FRAC_BITS) - 1);
      4:    req.divisor = top[DIVISOR_W-1:0] + $urandom_range(0, 3);
      default: begin
        top = top >> $urandom_range(0, DATA_WIDTH + FRAC_BITS - 1);
        req.divisor = top[DIVISOR_W-1:0] ^ ($urandom & ((1 << FRAC_BITS) - 1));
        if (64'(req.divisor) > (mag << FRAC_BITS)) req.divisor = top[DIVISOR_W-1:0];
      end
    endcase
    return req;
  endfunction

  // sender: bursts of back-to-back transactions separated by random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      dut_start <= 1'b0;
    end else if (!dut_start || took_division) begin
      if (gap_left > 0) begin
        gap_left--;
        dut_start <= 1'b0;
      end else if (pending_divisions.size() != 0) begin
        dut_start <= 1'b1;
        dut_req <= pending_divisions.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
        end
      end else begin
        dut_start <= 1'b0;
      end
    end
  end

  // results are compared before the new transaction is queued
  always @(posedge clk_i) begin
    nsd_rsp_t exp_rsp;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_quotients.size() == 0) begin
          $display("%0t: result with no transaction pending: quotient %0d status %0d",
                   $time, rsp_o.quotient, rsp_o.status);
          error_count++;
        end else begin
          exp_rsp = expected_quotients.pop_front();
          if (rsp_o.quotient !== exp_rsp.quotient) begin
            $display("%0t: quotient mismatch: expected %0d, actual %0d",
                     $time, exp_rsp.quotient, rsp_o.quotient);
            error_count++;
          end
          if (rsp_o.status !== exp_rsp.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_rsp.status, rsp_o.status);
            error_count++;
          end
        end
      end
      if (dut_start && !busy) expected_quotients.push_back(predict_quotient(dut_req));
      took_division <= dut_start && !busy;
    end
  end

  initial begin
    queue_division('0, '0);
    queue_division('0, 1);
    queue_division('0, '1);
    queue_division(3, 4 * ONE_FIXED);
    queue_division(5, 5 * ONE_FIXED);
    queue_division(-5, 5 * ONE_FIXED);
    queue_division(DIVIDEND_MIN, ONE_FIXED);
    queue_division(DIVIDEND_MIN, 1);
    queue_division(DIVIDEND_MIN, ONE_FIXED << (DATA_WIDTH - 1));
    queue_division(DIVIDEND_MIN, '1);
    queue_division(DIVIDEND_MAX, ONE_FIXED);
    queue_division(DIVIDEND_MAX, '1);
    queue_division(DIVIDEND_MAX, 1);
    queue_division(DIVIDEND_MAX, 3);
    queue_division(1 << (DATA_WIDTH - 2), 1);
    queue_division(1, 1);
    queue_division(-1, ONE_FIXED);
    queue_division(-1, 1);
    queue_division(7, ONE_FIXED + 1);
    queue_division(-1000, 3 * ONE_FIXED + (ONE_FIXED >> 1));
    queue_division(DIVIDEND_MAX, DIVIDEND_MAX * ONE_FIXED);
    queue_division(DIVIDEND_MAX, DIVIDEND_MAX * ONE_FIXED + 1);
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_divisions.push_back(random_division());

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_divisions.size() != 0 || dut_start || expected_quotients.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/nsd_pkg.sv
rtl/normalized_signed_divider_core.sv
tb/tb_normalized_signed_divider_core.sv
